// ===== src/fprc_pkg.sv =====
// Shared types and constants of the framed packet receiver.
// Used by the channel interfaces, the payload bank store and the top level.
package fprc_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned EVENT_W     = 3;
   localparam int unsigned LENGTH_W    = 16;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned BANK_ADDR_W = INDEX_W + 1;

   localparam logic [DATA_W-1:0] CRC_POLY         = 8'h31;
   localparam logic [DATA_W-1:0] SYNC_FIRST_INIT  = 8'd75;
   localparam logic [DATA_W-1:0] SYNC_SECOND_INIT = 8'd83;

   typedef enum logic [CMD_W-1:0] {
      CMD_BYTE    = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_RESET   = 2'd2,
      CMD_READ    = 2'd3
   } command_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_CONSUMED = 3'd0,
      EV_TEXT     = 3'd1,
      EV_SKIPPED  = 3'd2,
      EV_ACCEPTED = 3'd3,
      EV_CRC_ERR  = 3'd4,
      EV_OVERFLOW = 3'd5,
      EV_DROPPED  = 3'd6,
      EV_ACK      = 3'd7
   } event_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_FIRST  = 1'b0,
      CSR_SYNC_SECOND = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                   en;
      logic [BANK_ADDR_W-1:0] addr;
      logic [DATA_W-1:0]      data;
   } bank_wr_type;

   typedef struct packed {
      logic                   en;
      logic                   ok;
      logic [BANK_ADDR_W-1:0] addr;
   } bank_rd_type;

   // CRC-8, MSB first, one byte
   function automatic logic [DATA_W-1:0] crc8_step(input logic [DATA_W-1:0] crc,
                                                   input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== src/fprc_ifs.sv =====
// Valid/ready channel interfaces: request, response and register write.
// Depends on fprc_pkg for field widths.
interface fprc_req_if;
   import fprc_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [DATA_W-1:0]   data_byte;
   logic                buffer_start;
   logic [INDEX_W-1:0]  read_index;
   modport source (output valid, command, data_byte, buffer_start, read_index, input ready);
   modport sink   (input valid, command, data_byte, buffer_start, read_index, output ready);
endinterface

interface fprc_rsp_if;
   import fprc_pkg::*;
   logic                valid;
   logic                ready;
   logic [EVENT_W-1:0]  event_res;
   logic [DATA_W-1:0]   frame_cmd;
   logic [LENGTH_W-1:0] frame_length;
   logic [DATA_W-1:0]   expected_crc;
   logic [DATA_W-1:0]   read_data;
   logic                frame_held;
   modport source (output valid, event_res, frame_cmd, frame_length, expected_crc,
                   read_data, frame_held, input ready);
   modport sink   (input valid, event_res, frame_cmd, frame_length, expected_crc,
                   read_data, frame_held, output ready);
endinterface

interface fprc_csr_if;
   import fprc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== src/framed_packet_receiver_crc8.sv =====
// Top level of the framed packet receiver with CRC-8 check.
// Depends on fprc_pkg, the channel interfaces and fprc_bank_store.
//
// req_bus carries one item per byte or host command; rsp_bus returns exactly
// one result item for each request item, in order. csr_bus writes the two
// sync byte registers (index 0 first, index 1 second) and is always ready;
// write it only while no item is in flight.
// A result is registered and is valid on the cycle after its request is accepted.
// One item is accepted per cycle while rsp_bus does not stall. Parser
// state is updated in the accept cycle; the held payload byte for a read
// comes from the bank store's registered read port, valid with the result.
// The result register is the only stage: while rsp_bus stalls, req_bus.ready
// drops and the held result and read data stay stable.
// Reset (synchronous) returns the parser to idle, frees the held bank and
// restores the sync registers to 0x4B and 0x53. The payload banks are not
// cleared; only bytes of a held frame are ever read back.
module framed_packet_receiver_crc8 #(
   parameter int PAYLOAD_MAX = 1024
) (
   input  logic              clock,
   input  logic              reset,
   fprc_req_if.sink          req_bus,
   fprc_rsp_if.source        rsp_bus,
   fprc_csr_if.sink          csr_bus
);
   import fprc_pkg::*;

   localparam int BANK_DEPTH = (PAYLOAD_MAX < 1024) ? PAYLOAD_MAX : 1024;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int LEN_W      = $clog2(PAYLOAD_MAX + 1);
   localparam int POS_W      = 11;
   localparam logic [POS_W-1:0]    BANK_LIM = POS_W'(BANK_DEPTH);
   localparam logic [LENGTH_W-1:0] MAX_LEN  = LENGTH_W'(PAYLOAD_MAX);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_HEADER  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHECK   = 3'd4
   } phase_type;

   logic [DATA_W-1:0]   sync_first_ff, sync_first_in;
   logic [DATA_W-1:0]   sync_second_ff, sync_second_in;
   phase_type           phase_ff, phase_in;
   logic [1:0]          header_pos_ff, header_pos_in;
   logic [DATA_W-1:0]   cur_cmd_ff, cur_cmd_in;
   logic [LENGTH_W-1:0] cur_length_ff, cur_length_in;
   logic [POS_W-1:0]    payload_pos_ff, payload_pos_in;
   logic [DATA_W-1:0]   crc_ff, crc_in;
   logic                committed_ff, committed_in;
   logic                text_ff, text_in;
   logic                bank_ff, bank_in;
   logic                held_valid_ff, held_valid_in;
   logic [DATA_W-1:0]   held_cmd_ff, held_cmd_in;
   logic [LEN_W-1:0]    held_len_ff, held_len_in;

   logic                out_valid_ff, out_valid_in;
   event_code_type      out_event_ff, out_event_in;
   logic [DATA_W-1:0]   out_cmd_ff, out_cmd_in;
   logic [LENGTH_W-1:0] out_len_ff, out_len_in;
   logic [DATA_W-1:0]   out_crc_ff, out_crc_in;
   logic                out_held_ff, out_held_in;

   logic                accept;
   logic                committed_v;
   logic                text_v;
   logic [DATA_W-1:0]   b;
   logic [POS_W-1:0]    pos_next;
   logic [LENGTH_W-1:0] len_full;
   bank_wr_type         bank_wr;
   bank_rd_type         bank_rd;
   logic [DATA_W-1:0]   bank_rdata;

   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;
   assign pos_next      = payload_pos_ff + 1'b1;
   assign len_full      = {b, cur_length_ff[7:0]};

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_SYNC_FIRST:  sync_first_in  = csr_bus.wdata;
            CSR_SYNC_SECOND: sync_second_in = csr_bus.wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      header_pos_in  = header_pos_ff;
      cur_cmd_in     = cur_cmd_ff;
      cur_length_in  = cur_length_ff;
      payload_pos_in = payload_pos_ff;
      crc_in         = crc_ff;
      committed_in   = committed_ff;
      text_in        = text_ff;
      bank_in        = bank_ff;
      held_valid_in  = held_valid_ff;
      held_cmd_in    = held_cmd_ff;
      held_len_in    = held_len_ff;
      committed_v    = committed_ff;
      text_v         = text_ff;
      out_event_in   = EV_ACK;
      out_crc_in     = '0;
      bank_wr        = '{en: 1'b0, addr: BANK_ADDR_W'({!bank_ff, payload_pos_ff[AW-1:0]}),
                         data: b};
      // every accepted item loads the read port; only a read may return data
      bank_rd        = '{en: accept,
                         ok: (command_type'(req_bus.command) == CMD_READ)
                             && held_valid_ff
                             && (LENGTH_W'(req_bus.read_index) < LENGTH_W'(held_len_ff))
                             && ({1'b0, req_bus.read_index} < BANK_LIM),
                         addr: BANK_ADDR_W'({bank_ff, req_bus.read_index[AW-1:0]})};

      if (accept) begin
         case (command_type'(req_bus.command))
            CMD_BYTE: begin
               if (req_bus.buffer_start) begin
                  committed_v = 1'b0;
                  text_v      = 1'b0;
               end
               committed_in = committed_v;
               text_in      = text_v;
               if (text_v) begin
                  out_event_in = EV_TEXT;
               end else begin
                  out_event_in = EV_CONSUMED;
                  case (phase_ff)
                     PH_SYNC2: begin
                        if (b == sync_second_ff) begin
                           phase_in      = PH_HEADER;
                           header_pos_in = 2'd0;
                           committed_in  = 1'b1;
                        end else begin
                           phase_in = PH_IDLE;
                           if (!committed_v) begin
                              text_in      = 1'b1;
                              out_event_in = EV_TEXT;
                           end else begin
                              out_event_in = EV_SKIPPED;
                           end
                        end
                     end
                     PH_HEADER: begin
                        case (header_pos_ff)
                           2'd0: begin
                              cur_cmd_in    = b;
                              header_pos_in = 2'd1;
                           end
                           2'd1: begin
                              cur_length_in = LENGTH_W'(b);
                              header_pos_in = 2'd2;
                           end
                           default: begin
                              cur_length_in  = len_full;
                              header_pos_in  = 2'd0;
                              payload_pos_in = '0;
                              crc_in         = '0;
                              if (len_full > MAX_LEN) begin
                                 phase_in     = PH_IDLE;
                                 out_event_in = EV_OVERFLOW;
                              end else if (len_full == '0) begin
                                 phase_in = PH_CHECK;
                              end else begin
                                 phase_in = PH_PAYLOAD;
                              end
                           end
                        endcase
                     end
                     PH_PAYLOAD: begin
                        bank_wr.en     = payload_pos_ff < BANK_LIM;
                        crc_in         = crc8_step(crc_ff, b);
                        payload_pos_in = pos_next;
                        if (LENGTH_W'(pos_next) >= cur_length_ff) begin
                           phase_in = PH_CHECK;
                        end
                     end
                     PH_CHECK: begin
                        out_crc_in   = crc_ff;
                        phase_in     = PH_IDLE;
                        committed_in = 1'b0;
                        if (b != crc_ff) begin
                           out_event_in = EV_CRC_ERR;
                        end else if (held_valid_ff) begin
                           out_event_in = EV_DROPPED;
                        end else begin
                           held_valid_in = 1'b1;
                           held_cmd_in   = cur_cmd_ff;
                           held_len_in   = cur_length_ff[LEN_W-1:0];
                           bank_in       = !bank_ff;
                           out_event_in  = EV_ACCEPTED;
                        end
                     end
                     default: begin
                        if (b == sync_first_ff) begin
                           phase_in = PH_SYNC2;
                        end else begin
                           phase_in = PH_IDLE;
                           if (!committed_v) begin
                              text_in      = 1'b1;
                              out_event_in = EV_TEXT;
                           end else begin
                              out_event_in = EV_SKIPPED;
                           end
                        end
                     end
                  endcase
               end
            end
            CMD_RELEASE: begin
               held_valid_in = 1'b0;
            end
            CMD_RESET: begin
               phase_in       = PH_IDLE;
               header_pos_in  = 2'd0;
               payload_pos_in = '0;
               held_valid_in  = 1'b0;
            end
            CMD_READ: begin
               bank_rd.en = 1'b1;
            end
            default: ;
         endcase
      end

      if (accept && (command_type'(req_bus.command) == CMD_BYTE)) begin
         out_cmd_in = cur_cmd_in;
         out_len_in = cur_length_in;
      end else begin
         out_cmd_in = held_cmd_ff;
         out_len_in = LENGTH_W'(held_len_ff);
      end
      out_held_in = held_valid_in;

      if (accept) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_INIT;
         sync_second_ff <= SYNC_SECOND_INIT;
         phase_ff       <= PH_IDLE;
         header_pos_ff  <= '0;
         cur_cmd_ff     <= '0;
         cur_length_ff  <= '0;
         payload_pos_ff <= '0;
         crc_ff         <= '0;
         committed_ff   <= 1'b0;
         text_ff        <= 1'b0;
         bank_ff        <= 1'b0;
         held_valid_ff  <= 1'b0;
         held_cmd_ff    <= '0;
         held_len_ff    <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         phase_ff       <= phase_in;
         header_pos_ff  <= header_pos_in;
         cur_cmd_ff     <= cur_cmd_in;
         cur_length_ff  <= cur_length_in;
         payload_pos_ff <= payload_pos_in;
         crc_ff         <= crc_in;
         committed_ff   <= committed_in;
         text_ff        <= text_in;
         bank_ff        <= bank_in;
         held_valid_ff  <= held_valid_in;
         held_cmd_ff    <= held_cmd_in;
         held_len_ff    <= held_len_in;
         out_valid_ff   <= out_valid_in;
      end
      if (accept) begin
         out_event_ff <= out_event_in;
         out_cmd_ff   <= out_cmd_in;
         out_len_ff   <= out_len_in;
         out_crc_ff   <= out_crc_in;
         out_held_ff  <= out_held_in;
      end
   end

   fprc_bank_store #(
      .AW (AW)
   ) u_bank_store (
      .clock (clock),
      .wr    (bank_wr),
      .rd    (bank_rd),
      .rdata (bank_rdata)
   );

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.event_res    = out_event_ff;
   assign rsp_bus.frame_cmd    = out_cmd_ff;
   assign rsp_bus.frame_length = out_len_ff;
   assign rsp_bus.expected_crc = out_crc_ff;
   assign rsp_bus.read_data    = bank_rdata;
   assign rsp_bus.frame_held   = out_held_ff;

`ifndef NO_ASSERTIONS
   a_header_pos_range: assert property (@(posedge clock) disable iff (reset)
      header_pos_ff != 2'd3)
      else $error("header position out of range");

   a_held_rise_accept: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(held_valid_ff) |-> out_event_ff == EV_ACCEPTED)
      else $error("held frame set without accepted event");

   a_bank_flip_accept: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(bank_ff) |-> out_event_ff == EV_ACCEPTED && out_valid_ff)
      else $error("bank flipped without accepted frame");

   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> out_valid_ff)
      else $error("request stalled with empty result register");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> cur_length_ff != '0)
      else $error("payload phase with zero length");
`endif

endmodule

// ===== src/fprc_bank_store.sv =====
// Two-bank payload byte store: one write port, one registered read port.
// Depends on fprc_pkg for the port structs.
module fprc_bank_store #(
   parameter int AW = 10
) (
   input  logic                     clock,
   input  fprc_pkg::bank_wr_type    wr,
   input  fprc_pkg::bank_rd_type    rd,
   output logic [fprc_pkg::DATA_W-1:0] rdata
);
   import fprc_pkg::*;

   logic [DATA_W-1:0] mem [2**(AW+1)];
   logic [DATA_W-1:0] q_ff;
   logic              ok_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW:0]] <= wr.data;
      end
      if (rd.en) begin
         q_ff  <= mem[rd.addr[AW:0]];
         ok_ff <= rd.ok;
      end
   end

   // reads out of range or with no held frame return zero
   assign rdata = ok_ff ? q_ff : '0;

endmodule

// ===== tb/tb_framed_packet_receiver_crc8.sv =====
// Testbench for framed_packet_receiver_crc8: drives link bytes and host commands, predicts
// every result item with an in-bench parser model and checks it field by field.
// Depends on fprc_pkg, the channel interfaces in fprc_ifs and the top level.
`timescale 1ns / 1ps

module tb_framed_packet_receiver_crc8;
   import fprc_pkg::*;

   localparam int PAYLOAD_MAX = 1024;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic [2:0] {
      RX_IDLE, RX_SYNC2, RX_HEADER, RX_PAYLOAD, RX_CHECK
   } rx_state_type;

   typedef struct packed {
      command_type          cmd;
      logic [DATA_W-1:0]    data;
      logic                 start;
      logic [INDEX_W-1:0]   idx;
   } link_item_type;

   typedef struct packed {
      event_code_type       ev;
      logic [DATA_W-1:0]    fcmd;
      logic [LENGTH_W-1:0]  flen;
      logic [DATA_W-1:0]    ecrc;
      logic [DATA_W-1:0]    rdata;
      logic                 held;
   } parser_result_type;

   logic clock;
   logic reset;

   fprc_req_if req_bus ();
   fprc_rsp_if rsp_bus ();
   fprc_csr_if csr_bus ();

   framed_packet_receiver_crc8 #(.PAYLOAD_MAX(PAYLOAD_MAX)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // parser model state
   logic [DATA_W-1:0]   sync_first_cfg;
   logic [DATA_W-1:0]   sync_second_cfg;
   rx_state_type        rx_state;
   logic [1:0]          hdr_pos;
   logic [DATA_W-1:0]   cur_id;
   logic [LENGTH_W-1:0] cur_len;
   logic [10:0]         pay_pos;
   logic [DATA_W-1:0]   pay_crc;
   logic                hdr_committed;
   logic                text_mode;
   logic [DATA_W-1:0]   bank_bytes [0:2*PAYLOAD_MAX-1];
   logic                bank_sel;
   logic                held_busy;
   logic [DATA_W-1:0]   held_id;
   logic [10:0]         held_len;

   link_item_type       link_items [$];
   parser_result_type   parser_results_due [$];
   link_item_type       offered;
   int unsigned         generated = 0;
   int unsigned         error_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         results_seen = 0;

   function automatic logic [DATA_W-1:0] crc8_next(input logic [DATA_W-1:0] acc,
                                                   input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] r;
      r = acc ^ b;
      repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      return r;
   endfunction

   function automatic event_code_type parse_link_byte(input logic [DATA_W-1:0] b);
      int unsigned addr;
      case (rx_state)
         RX_SYNC2: begin
            if (b == sync_second_cfg) begin
               rx_state = RX_HEADER;
               hdr_pos = 2'd0;
               hdr_committed = 1'b1;
               return EV_CONSUMED;
            end
            rx_state = RX_IDLE;
            if (!hdr_committed) begin
               text_mode = 1'b1;
               return EV_TEXT;
            end
            return EV_SKIPPED;
         end
         RX_HEADER: begin
            if (hdr_pos == 2'd0) begin
               cur_id = b;
               hdr_pos = 2'd1;
               return EV_CONSUMED;
            end
            if (hdr_pos == 2'd1) begin
               cur_len = {8'h00, b};
               hdr_pos = 2'd2;
               return EV_CONSUMED;
            end
            cur_len = {b, cur_len[7:0]};
            hdr_pos = 2'd0;
            pay_pos = '0;
            pay_crc = '0;
            if (cur_len > PAYLOAD_MAX) begin
               rx_state = RX_IDLE;
               return EV_OVERFLOW;
            end
            rx_state = (cur_len == 0) ? RX_CHECK : RX_PAYLOAD;
            return EV_CONSUMED;
         end
         RX_PAYLOAD: begin
            if (pay_pos < PAYLOAD_MAX) begin
               addr = (bank_sel ? 0 : PAYLOAD_MAX) + pay_pos;
               bank_bytes[addr] = b;
            end
            pay_crc = crc8_next(pay_crc, b);
            pay_pos = pay_pos + 11'd1;
            if (pay_pos >= cur_len) rx_state = RX_CHECK;
            return EV_CONSUMED;
         end
         RX_CHECK: begin
            rx_state = RX_IDLE;
            hdr_committed = 1'b0;
            if (b != pay_crc) return EV_CRC_ERR;
            if (held_busy) return EV_DROPPED;
            held_busy = 1'b1;
            held_id = cur_id;
            held_len = cur_len[10:0];
            bank_sel = !bank_sel;
            return EV_ACCEPTED;
         end
         default: begin
            rx_state = RX_IDLE;
            if (b == sync_first_cfg) begin
               rx_state = RX_SYNC2;
               return EV_CONSUMED;
            end
            if (!hdr_committed) begin
               text_mode = 1'b1;
               return EV_TEXT;
            end
            return EV_SKIPPED;
         end
      endcase
   endfunction

   function automatic parser_result_type predict_parser_result(input link_item_type it);
      parser_result_type r;
      r = '0;
      r.ev = EV_ACK;
      if (it.cmd == CMD_BYTE) begin
         if (it.start) begin
            text_mode = 1'b0;
            hdr_committed = 1'b0;
         end
         if (text_mode) begin
            r.ev = EV_TEXT;
         end else begin
            if (rx_state == RX_CHECK) r.ecrc = pay_crc;
            r.ev = parse_link_byte(it.data);
         end
         r.fcmd = cur_id;
         r.flen = cur_len;
      end else begin
         case (it.cmd)
            CMD_RELEASE: held_busy = 1'b0;
            CMD_RESET: begin
               rx_state = RX_IDLE;
               hdr_pos = 2'd0;
               pay_pos = '0;
               held_busy = 1'b0;
            end
            default: begin
               if (held_busy && it.idx < held_len)
                  r.rdata = bank_bytes[(bank_sel ? PAYLOAD_MAX : 0) + it.idx];
            end
         endcase
         r.fcmd = held_id;
         r.flen = {5'd0, held_len};
      end
      r.held = held_busy;
      return r;
   endfunction

   function automatic void check_field(input string what, input logic [15:0] got,
                                       input logic [15:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
         error_count++;
      end
   endfunction

   task automatic queue_byte(input logic [DATA_W-1:0] b, input bit start);
      link_item_type it;
      it.cmd = CMD_BYTE;
      it.data = b;
      it.start = start;
      it.idx = INDEX_W'($urandom_range(0, 1023));
      link_items.push_back(it);
      generated++;
   endtask

   task automatic queue_command(input command_type c, input logic [INDEX_W-1:0] idx);
      link_item_type it;
      it.cmd = c;
      it.data = DATA_W'($urandom_range(0, 255));
      it.start = 1'($urandom_range(0, 1));
      it.idx = idx;
      link_items.push_back(it);
      generated++;
   endtask

   // cut = 0 or a cut beyond the frame sends the whole frame, otherwise only its first cut bytes
   task automatic queue_frame(input logic [DATA_W-1:0] id, input int unsigned len,
                              input bit fresh, input bit corrupt, input bit span,
                              input int unsigned cut);
      logic [DATA_W-1:0] bytes [$];
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] b;
      int unsigned n;
      int unsigned span_at;
      int unsigned i;
      acc = '0;
      bytes.push_back(sync_first_cfg);
      bytes.push_back(sync_second_cfg);
      bytes.push_back(id);
      bytes.push_back(8'(len));
      bytes.push_back(8'(len >> 8));
      if (len <= PAYLOAD_MAX) begin
         repeat (len) begin
            b = DATA_W'($urandom_range(0, 255));
            acc = crc8_next(acc, b);
            bytes.push_back(b);
         end
         bytes.push_back(corrupt ? (acc ^ DATA_W'($urandom_range(1, 255))) : acc);
      end
      n = (cut != 0 && cut < bytes.size()) ? cut : bytes.size();
      span_at = $urandom_range(1, bytes.size() - 1);
      for (i = 0; i < n; i++) begin
         queue_byte(bytes[i], (i == 0) ? fresh : (span && i == span_at));
      end
   endtask

   task automatic queue_random_traffic(input int unsigned budget);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned len;
      stop_at = generated + budget;
      while (generated < stop_at) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) :
               ($urandom_range(0, 5) != 0) ? $urandom_range(9, 64) : $urandom_range(65, 200);
         if (pick < 55) begin
            queue_frame(DATA_W'($urandom_range(0, 255)), len, $urandom_range(0, 3) != 0,
                        $urandom_range(0, 6) == 0, $urandom_range(0, 9) == 0, 0);
         end else if (pick < 68) begin
            repeat ($urandom_range(1, 4)) begin
               queue_command(CMD_READ, ($urandom_range(0, 3) == 0) ?
                             INDEX_W'($urandom_range(0, 1023)) :
                             INDEX_W'($urandom_range(0, 15)));
            end
         end else if (pick < 74) begin
            queue_command(CMD_RELEASE, INDEX_W'($urandom_range(0, 1023)));
         end else if (pick < 78) begin
            queue_frame(DATA_W'($urandom_range(0, 255)), len, 1'b1, 1'b0, 1'b0,
                        $urandom_range(1, len + 5));
            queue_command(CMD_RESET, INDEX_W'($urandom_range(0, 1023)));
         end else if (pick < 86) begin
            queue_byte(DATA_W'($urandom_range(0, 255)), 1'b1);
            repeat ($urandom_range(0, 6))
               queue_byte(DATA_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
         end else if (pick < 92) begin
            queue_frame(DATA_W'($urandom_range(0, 255)),
                        ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1025, 65534),
                        $urandom_range(0, 1), 1'b0, 1'b0, 0);
            if ($urandom_range(0, 1)) queue_byte(DATA_W'($urandom_range(0, 255)), 1'b0);
         end else begin
            queue_frame(DATA_W'($urandom_range(0, 255)), len, $urandom_range(0, 1), 1'b0,
                        1'b0, $urandom_range(1, len + 5));
         end
      end
   endtask

   task automatic write_sync(input csr_index_type idx, input logic [DATA_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= val;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_SYNC_FIRST) sync_first_cfg = val;
      else sync_second_cfg = val;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (link_items.size() != 0 || req_bus.valid || parser_results_due.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // sender: bursts of random length with random gaps
   int unsigned burst_left = 8;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            parser_results_due.push_back(predict_parser_result(offered));
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (link_items.size() != 0) begin
               offered = link_items.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.command      <= offered.cmd;
               req_bus.data_byte    <= offered.data;
               req_bus.buffer_start <= offered.start;
               req_bus.read_index   <= offered.idx;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern changes at random intervals, plus one long hold-off
   int unsigned stall_mode = 0;
   int unsigned stall_mode_left = 0;
   int unsigned stall_tick = 0;
   int unsigned hold_left = 0;
   bit          long_hold_done = 1'b0;
   parser_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (parser_results_due.size() == 0) begin
               $display("%0t: result with nothing expected, actual event %0d", $time,
                        rsp_bus.event_res);
               error_count++;
            end else begin
               want = parser_results_due.pop_front();
               check_field("event_res", 16'(rsp_bus.event_res), 16'(want.ev));
               check_field("frame_cmd", 16'(rsp_bus.frame_cmd), 16'(want.fcmd));
               check_field("frame_length", rsp_bus.frame_length, want.flen);
               check_field("expected_crc", 16'(rsp_bus.expected_crc), 16'(want.ecrc));
               check_field("read_data", 16'(rsp_bus.read_data), 16'(want.rdata));
               check_field("frame_held", 16'(rsp_bus.frame_held), 16'(want.held));
            end
         end
         stall_tick++;
         if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 120);
         end else begin
            stall_mode_left--;
         end
         if (!long_hold_done && results_seen == 600) begin
            hold_left = 400;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (stall_tick % 4 == 0);
               default: rsp_bus.ready <= (stall_tick % 3 != 0);
            endcase
         end
      end
   end

   logic [DATA_W-1:0] phase_first [0:4];
   logic [DATA_W-1:0] phase_second [0:4];
   int unsigned       phase_budget [0:4];

   initial begin
      sync_first_cfg = SYNC_FIRST_INIT;
      sync_second_cfg = SYNC_SECOND_INIT;
      rx_state = RX_IDLE;
      hdr_pos = 2'd0;
      cur_id = '0;
      cur_len = '0;
      pay_pos = '0;
      pay_crc = '0;
      hdr_committed = 1'b0;
      text_mode = 1'b0;
      bank_sel = 1'b0;
      held_busy = 1'b0;
      held_id = '0;
      held_len = '0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_BYTE;
      req_bus.data_byte = '0;
      req_bus.buffer_start = 1'b0;
      req_bus.read_index = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_SYNC_FIRST;
      csr_bus.wdata = '0;
      phase_first = '{8'h00, 8'hFF, 8'hA5, DATA_W'($urandom_range(0, 255)), SYNC_FIRST_INIT};
      phase_second = '{8'hFF, 8'h00, 8'hA5, DATA_W'($urandom_range(0, 255)), SYNC_SECOND_INIT};
      phase_budget = '{40, 40, 30, 30, 20};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // text buffer, then a zero-length frame that is held
      queue_byte(8'h00, 1'b1);
      queue_byte(sync_first_cfg, 1'b0);
      queue_frame(8'hFF, 0, 1'b1, 1'b0, 1'b0, 0);
      queue_command(CMD_READ, '0);
      // oversize header, then stray bytes and a failed second sync
      queue_frame(8'h00, PAYLOAD_MAX + 1, 1'b1, 1'b0, 1'b0, 0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(sync_first_cfg, 1'b0);
      queue_byte(8'h00, 1'b0);
      // good frame while one is held is dropped
      queue_frame(8'h5A, 3, 1'b0, 1'b0, 1'b0, 0);
      queue_command(CMD_READ, 10'h3FF);
      queue_command(CMD_RELEASE, '0);
      queue_frame(8'hA5, 2, 1'b1, 1'b1, 1'b0, 0);
      queue_frame(8'h3C, 4, 1'b1, 1'b0, 1'b0, 4);
      queue_command(CMD_RESET, 10'h155);
      queue_random_traffic(40);

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         write_sync(CSR_SYNC_FIRST, phase_first[p]);
         write_sync(CSR_SYNC_SECOND, phase_second[p]);
         if (p == 0) begin
            queue_command(CMD_RELEASE, '0);
            queue_frame(8'h80, PAYLOAD_MAX, 1'b1, 1'b0, 1'b0, 0);
            queue_command(CMD_READ, '0);
            queue_command(CMD_READ, 10'h3FF);
            queue_command(CMD_READ, INDEX_W'($urandom_range(0, 1023)));
         end
         queue_random_traffic(phase_budget[p]);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0 && parser_results_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
